[hdl/fac_pkg.sv]
`timescale 1ns / 1ps
package fac_pkg;

  localparam int N_ENT  = 16;
  localparam int IDX_W  = 4;
  localparam int CNT_W  = 5;
  localparam int KEY_W  = 32;
  localparam int TIME_W = 32;
  localparam int USES_W = 16;
  localparam int AGE_W  = TIME_W + 1;     // age + 1
  localparam int PROD_W = USES_W + AGE_W;

  localparam logic       CMD_ACCESS = 1'b0;
  localparam logic       CMD_CLEAR  = 1'b1;
  localparam logic [USES_W-1:0] USES_MAX = '1;
  localparam logic [CNT_W-1:0]  CAP_RESET = CNT_W'(N_ENT);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_DECIDE,
    S_EV_LOAD,
    S_EV_MA,
    S_EV_MB,
    S_EV_CMP,
    S_EV_KILL,
    S_INSERT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic clear;
    logic hit_upd;
    logic scan_start;
    logic load_cur;
    logic mul_a;
    logic mul_b;
    logic take_cur;
    logic step;
    logic kill;
    logic insert;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic hit;
    logic need_evict;
    logic cur_valid;
    logic best_found;
    logic a_less;
    logic last;
  } dp_sts_t;

endpackage

[hdl/fac_ctrl.sv]
`timescale 1ns / 1ps
module fac_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  fac_pkg::dp_sts_t sts,
  output fac_pkg::dp_cmd_t cmd
);
  import fac_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_LOOK;
      S_LOOK:    state_nxt = sts.is_clear ? S_DONE : S_DECIDE;
      S_DECIDE: begin
        priority if (sts.hit)        state_nxt = S_DONE;
        else if (sts.need_evict)     state_nxt = S_EV_LOAD;
        else                         state_nxt = S_INSERT;
      end
      S_EV_LOAD: begin
        priority if (sts.cur_valid) state_nxt = S_EV_MA;
        else if (sts.last)          state_nxt = S_EV_KILL;
        else                        state_nxt = S_EV_LOAD;
      end
      S_EV_MA:   state_nxt = S_EV_MB;
      S_EV_MB:   state_nxt = S_EV_CMP;
      S_EV_CMP:  state_nxt = sts.last ? S_EV_KILL : S_EV_LOAD;
      S_EV_KILL: state_nxt = S_DECIDE;
      S_INSERT:  state_nxt = S_DONE;
      S_DONE:    if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE:    cmd.capture = in_valid;
      S_LOOK: begin
        cmd.lookup = 1'b1;
        cmd.clear  = sts.is_clear;
      end
      S_DECIDE: begin
        cmd.hit_upd    = sts.hit;
        cmd.scan_start = !sts.hit && sts.need_evict;
      end
      S_EV_LOAD: begin
        cmd.load_cur = 1'b1;
        cmd.step     = !sts.cur_valid;
      end
      S_EV_MA:   cmd.mul_a = 1'b1;
      S_EV_MB:   cmd.mul_b = 1'b1;
      S_EV_CMP: begin
        // first valid entry seeds the running minimum
        cmd.take_cur = !sts.best_found || sts.a_less;
        cmd.step     = 1'b1;
      end
      S_EV_KILL: cmd.kill = 1'b1;
      S_INSERT:  cmd.insert = 1'b1;
      S_DONE: begin
        cmd.load_out = out_free;
        if (out_free) out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

[hdl/fac_dp.sv]
`timescale 1ns / 1ps
module fac_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [fac_pkg::CNT_W-1:0]    cfg_data,
  input  logic                         in_cmd,
  input  logic [fac_pkg::KEY_W-1:0]    in_key,
  input  logic                         in_create_ok,
  input  fac_pkg::dp_cmd_t             cmd,
  output fac_pkg::dp_sts_t             sts,
  output logic                         out_hit,
  output logic                         out_inserted,
  output logic [fac_pkg::IDX_W-1:0]    out_slot,
  output logic [fac_pkg::CNT_W-1:0]    out_evicted_count,
  output logic [fac_pkg::CNT_W-1:0]    out_occupancy
);
  import fac_pkg::*;

  logic [CNT_W-1:0]  cap_r;
  logic [N_ENT-1:0]  valid_r;
  logic [KEY_W-1:0]  tag_r   [N_ENT];
  logic [USES_W-1:0] uses_r  [N_ENT];
  logic [TIME_W-1:0] stamp_r [N_ENT];
  logic [TIME_W-1:0] clock_r;
  logic [CNT_W-1:0]  count_r;

  logic              op_r, ok_r;
  logic [KEY_W-1:0]  key_r;
  logic              hit_r, ins_r;
  logic [IDX_W-1:0]  hit_idx_r, slot_r;
  logic [CNT_W-1:0]  evc_r;

  logic [IDX_W-1:0]  idx_r;
  logic [USES_W-1:0] cur_uses_r, best_uses_r;
  logic [AGE_W-1:0]  cur_agep1_r, best_agep1_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic              best_found_r;
  logic [PROD_W-1:0] prod_a_r, prod_b_r;

  logic              oh_r, oi_r;
  logic [IDX_W-1:0]  os_r;
  logic [CNT_W-1:0]  oe_r, oo_r;

  // effective capacity: 0 acts as 1, above table size saturates
  logic [CNT_W-1:0] cap_eff;
  always_comb begin
    priority if (cap_r == '0)          cap_eff = CNT_W'(1);
    else if (cap_r > CNT_W'(N_ENT))    cap_eff = CNT_W'(N_ENT);
    else                               cap_eff = cap_r;
  end

  logic             match_any, free_any;
  logic [IDX_W-1:0] match_idx, free_idx;
  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    free_any  = 1'b0;
    free_idx  = '0;
    for (int i = N_ENT - 1; i >= 0; i--) begin
      if (valid_r[i] && tag_r[i] == key_r) begin
        match_any = 1'b1;
        match_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  logic [TIME_W-1:0] cur_age;
  assign cur_age = clock_r - stamp_r[idx_r];

  // one shared multiplier for both cross products
  logic [USES_W-1:0] mul_u;
  logic [AGE_W-1:0]  mul_g;
  logic [PROD_W-1:0] mul_p;
  assign mul_u = cmd.mul_a ? cur_uses_r : best_uses_r;
  assign mul_g = cmd.mul_a ? best_agep1_r : cur_agep1_r;
  assign mul_p = PROD_W'(mul_u) * PROD_W'(mul_g);

  always_comb begin
    sts.is_clear   = (op_r == CMD_CLEAR);
    sts.hit        = hit_r;
    sts.need_evict = (count_r != '0) && (count_r >= cap_eff);
    sts.cur_valid  = valid_r[idx_r];
    sts.best_found = best_found_r;
    sts.a_less     = prod_a_r < prod_b_r;
    sts.last       = (idx_r == IDX_W'(N_ENT - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      valid_r <= '0;
      clock_r <= '0;
      count_r <= '0;
    end else begin
      if (cfg_we) cap_r <= cfg_data;
      if (cmd.clear) begin
        valid_r <= '0;
        clock_r <= '0;
        count_r <= '0;
      end
      if (cmd.hit_upd) begin
        clock_r <= clock_r + TIME_W'(1);
      end
      if (cmd.kill) begin
        valid_r[best_idx_r] <= 1'b0;
        count_r <= count_r - CNT_W'(1);
      end
      if (cmd.insert && ok_r && free_any) begin
        valid_r[free_idx] <= 1'b1;
        clock_r <= clock_r + TIME_W'(1);
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_cmd;
      key_r <= in_key;
      ok_r  <= in_create_ok;
      ins_r <= 1'b0;
      slot_r <= '0;
      evc_r <= '0;
    end
    if (cmd.lookup) begin
      hit_r     <= match_any;
      hit_idx_r <= match_idx;
    end
    if (cmd.hit_upd) begin
      if (uses_r[hit_idx_r] != USES_MAX)
        uses_r[hit_idx_r] <= uses_r[hit_idx_r] + USES_W'(1);
      stamp_r[hit_idx_r] <= clock_r;
      slot_r <= hit_idx_r;
    end
    if (cmd.scan_start) begin
      idx_r        <= '0;
      best_found_r <= 1'b0;
    end
    if (cmd.load_cur) begin
      cur_uses_r  <= uses_r[idx_r];
      cur_agep1_r <= AGE_W'(cur_age) + AGE_W'(1);
    end
    if (cmd.mul_a) prod_a_r <= mul_p;
    if (cmd.mul_b) prod_b_r <= mul_p;
    if (cmd.take_cur) begin
      best_found_r <= 1'b1;
      best_idx_r   <= idx_r;
      best_uses_r  <= cur_uses_r;
      best_agep1_r <= cur_agep1_r;
    end
    if (cmd.step) idx_r <= idx_r + IDX_W'(1);
    if (cmd.kill) evc_r <= evc_r + CNT_W'(1);
    if (cmd.insert && ok_r && free_any) begin
      tag_r[free_idx]   <= key_r;
      uses_r[free_idx]  <= USES_W'(1);
      stamp_r[free_idx] <= clock_r;
      ins_r  <= 1'b1;
      slot_r <= free_idx;
    end
    if (cmd.load_out) begin
      oh_r <= (op_r == CMD_ACCESS) && hit_r;
      oi_r <= (op_r == CMD_ACCESS) && ins_r;
      os_r <= (op_r == CMD_ACCESS) ? slot_r : '0;
      oe_r <= (op_r == CMD_ACCESS) ? evc_r : '0;
      oo_r <= count_r;
    end
  end

  assign out_hit           = oh_r;
  assign out_inserted      = oi_r;
  assign out_slot          = os_r;
  assign out_evicted_count = oe_r;
  assign out_occupancy     = oo_r;

endmodule

[hdl/frequency_age_cache_replacement.sv]
`timescale 1ns / 1ps
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | in_cmd, in_key, in_create_ok
// out     | output    | out_valid / out_ready | out_hit, out_inserted, out_slot,
//         |           |                       | out_evicted_count, out_occupancy
// cfg     | input     | cfg_we                | cfg_data (capacity)
// One item at a time. Clear runs LOOK, DONE; a hit LOOK, DECIDE, DONE; a miss adds
// INSERT. Each eviction scans all 16 slots; each valid slot takes EV_LOAD, EV_MA,
// EV_MB and EV_CMP, as the single shared multiplier forms both cross products.
// Synchronous active-low reset empties the table and zeroes the access clock.
// A result waits in the output register; the next item is taken meanwhile
// and only stalls at its end while out_ready stays low.
module frequency_age_cache_replacement (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [fac_pkg::CNT_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_cmd,
  input  logic [fac_pkg::KEY_W-1:0]    in_key,
  input  logic                         in_create_ok,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_hit,
  output logic                         out_inserted,
  output logic [fac_pkg::IDX_W-1:0]    out_slot,
  output logic [fac_pkg::CNT_W-1:0]    out_evicted_count,
  output logic [fac_pkg::CNT_W-1:0]    out_occupancy
);
  import fac_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  fac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fac_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .in_cmd            (in_cmd),
    .in_key            (in_key),
    .in_create_ok      (in_create_ok),
    .cmd               (cmd),
    .sts               (sts),
    .out_hit           (out_hit),
    .out_inserted      (out_inserted),
    .out_slot          (out_slot),
    .out_evicted_count (out_evicted_count),
    .out_occupancy     (out_occupancy)
  );

endmodule

[tb/tb_frequency_age_cache_replacement.sv]
`timescale 1ns / 1ps
module tb_frequency_age_cache_replacement;
  import fac_pkg::*;

  localparam int RAND_ITEMS = 1800;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cmd = CMD_ACCESS;
  logic [KEY_W-1:0] in_key = '0;
  logic in_create_ok = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit, out_inserted;
  logic [IDX_W-1:0] out_slot;
  logic [CNT_W-1:0] out_evicted_count, out_occupancy;

  always #5 clk = ~clk;

  frequency_age_cache_replacement u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd), .in_key(in_key),
    .in_create_ok(in_create_ok), .out_valid(out_valid), .out_ready(out_ready),
    .out_hit(out_hit), .out_inserted(out_inserted), .out_slot(out_slot),
    .out_evicted_count(out_evicted_count), .out_occupancy(out_occupancy)
  );

  typedef struct packed {
    logic hit;
    logic inserted;
    logic [IDX_W-1:0] slot;
    logic [CNT_W-1:0] evicted;
    logic [CNT_W-1:0] occ;
  } lookup_res_t;

  typedef struct {
    logic cmd;
    logic [KEY_W-1:0] key;
    logic create_ok;
    logic fixed;
    lookup_res_t res;
  } stim_row_t;

  // table state mirror
  logic ent_valid [N_ENT];
  logic [KEY_W-1:0] ent_tag [N_ENT];
  logic [USES_W-1:0] ent_uses [N_ENT];
  logic [TIME_W-1:0] ent_stamp [N_ENT];
  logic [TIME_W-1:0] acc_clock;
  int occ_count;
  logic [CNT_W-1:0] cap_reg;

  lookup_res_t pending_results[$];
  int errors = 0;
  int n_items = 0, n_results = 0, n_hits = 0, n_evicts = 0;
  int idle_pct = 30;
  int stall_cycles = 0;
  logic [KEY_W-1:0] key_pool [8];

  function automatic logic lower_score(int a, int b);
    logic [PROD_W-1:0] lhs, rhs;
    logic [TIME_W-1:0] age_a, age_b;
    age_a = acc_clock - ent_stamp[a];
    age_b = acc_clock - ent_stamp[b];
    lhs = PROD_W'(ent_uses[a]) * (PROD_W'(age_b) + 1);
    rhs = PROD_W'(ent_uses[b]) * (PROD_W'(age_a) + 1);
    return lhs < rhs;
  endfunction

  function automatic lookup_res_t predict_access(logic cmd, logic [KEY_W-1:0] key,
                                                 logic create_ok);
    lookup_res_t r;
    int cap, found, victim;
    r = '0;
    if (cmd == CMD_CLEAR) begin
      foreach (ent_valid[i]) ent_valid[i] = 1'b0;
      occ_count = 0;
      acc_clock = '0;
      return r;
    end
    cap = (cap_reg < 1) ? 1 : (cap_reg > N_ENT) ? N_ENT : cap_reg;
    found = -1;
    for (int i = 0; i < N_ENT; i++)
      if (found < 0 && ent_valid[i] && ent_tag[i] == key) found = i;
    if (found >= 0) begin
      if (ent_uses[found] != USES_MAX) ent_uses[found]++;
      ent_stamp[found] = acc_clock;
      acc_clock++;
      r.hit = 1'b1;
      r.slot = found[IDX_W-1:0];
    end else begin
      while (occ_count > 0 && occ_count >= cap) begin
        victim = -1;
        for (int i = 0; i < N_ENT; i++)
          if (ent_valid[i] && (victim < 0 || lower_score(i, victim))) victim = i;
        ent_valid[victim] = 1'b0;
        occ_count--;
        r.evicted++;
      end
      if (create_ok) begin
        for (int i = 0; i < N_ENT; i++)
          if (!r.inserted && !ent_valid[i]) begin
            ent_valid[i] = 1'b1;
            ent_tag[i] = key;
            ent_uses[i] = 1;
            ent_stamp[i] = acc_clock;
            acc_clock++;
            occ_count++;
            r.inserted = 1'b1;
            r.slot = i[IDX_W-1:0];
          end
      end
    end
    r.occ = occ_count[CNT_W-1:0];
    return r;
  endfunction

  task automatic send_item(logic cmd, logic [KEY_W-1:0] key, logic create_ok,
                           logic fixed, lookup_res_t res);
    lookup_res_t p;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    p = predict_access(cmd, key, create_ok);
    if (fixed && p !== res) begin
      $display("%0t: directed row disagrees: expected %p, predicted %p", $time, res, p);
      errors++;
    end
    pending_results.push_back(p);
    if (p.evicted != 0) n_evicts++;
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_key <= key;
    in_create_ok <= create_ok;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_items++;
  endtask

  task automatic drain_and_config(logic [CNT_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    cap_reg = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // result side
  always @(posedge clk) begin
    lookup_res_t got, want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{out_hit, out_inserted, out_slot, out_evicted_count, out_occupancy};
        n_results++;
        if (got.hit) n_hits++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.hit !== want.hit || got.inserted !== want.inserted ||
              got.slot !== want.slot || got.evicted !== want.evicted ||
              got.occ !== want.occ) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !in_valid &&
        pending_results.size() == 0)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles > STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  stim_row_t directed [$];

  function automatic stim_row_t row(logic cmd, logic [KEY_W-1:0] key, logic ok,
                                    logic fixed, lookup_res_t res);
    stim_row_t s;
    s.cmd = cmd; s.key = key; s.create_ok = ok; s.fixed = fixed; s.res = res;
    return s;
  endfunction

  initial begin
    lookup_res_t none;
    logic [KEY_W-1:0] k;
    logic [CNT_W-1:0] cap_set [6] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd9};
    none = '0;
    foreach (ent_valid[i]) begin
      ent_valid[i] = 1'b0; ent_tag[i] = '0; ent_uses[i] = '0; ent_stamp[i] = '0;
    end
    acc_clock = '0;
    occ_count = 0;
    cap_reg = CAP_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, failed create, hit, clear, capacity fill
    directed.push_back(row(CMD_ACCESS, 32'h0, 1'b0, 1'b1, '{0, 0, 0, 0, 0}));
    directed.push_back(row(CMD_ACCESS, 32'h0, 1'b1, 1'b1, '{0, 1, 0, 0, 1}));
    directed.push_back(row(CMD_ACCESS, 32'hFFFF_FFFF, 1'b1, 1'b1, '{0, 1, 1, 0, 2}));
    directed.push_back(row(CMD_ACCESS, 32'h0, 1'b1, 1'b1, '{1, 0, 0, 0, 2}));
    directed.push_back(row(CMD_ACCESS, 32'hFFFF_FFFF, 1'b0, 1'b1, '{1, 0, 1, 0, 2}));
    directed.push_back(row(CMD_CLEAR, 32'hFFFF_FFFF, 1'b1, 1'b1, none));
    for (int i = 0; i < 17; i++)
      directed.push_back(row(CMD_ACCESS, 32'hA5A5_0000 + i, 1'b1, 1'b0, none));
    directed.push_back(row(CMD_ACCESS, 32'h5A5A_5A5A, 1'b0, 1'b0, none));
    foreach (directed[i])
      send_item(directed[i].cmd, directed[i].key, directed[i].create_ok,
                directed[i].fixed, directed[i].res);

    for (int ph = 0; ph < 12; ph++) begin
      drain_and_config(cap_set[ph % 6]);
      if (ph % 6 == 1) begin
        // capacity of one: a miss evicts every valid entry before its insert
        send_item(CMD_ACCESS, 32'h1234_5678, 1'b1, 1'b0, none);
      end
      foreach (key_pool[i]) key_pool[i] = $urandom();
      idle_pct = (ph == 3) ? 0 : 30;
      for (int n = 0; n < RAND_ITEMS / 12; n++) begin
        case ($urandom_range(19))
          0: k = $urandom();
          1: k = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
          default: k = key_pool[$urandom_range(7)] ^ KEY_W'($urandom_range(3) == 0);
        endcase
        send_item(($urandom_range(59) == 0) ? CMD_CLEAR : CMD_ACCESS, k,
                  ($urandom_range(9) != 0), 1'b0, none);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d items through 12 capacity phases; %0d results, %0d hits,",
             n_items, n_results, n_hits);
    $display("%0d accesses with evictions, %0d errors", n_evicts, errors);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
